// ===== design/npcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_pkg
// Types and constants that the nearest palette colour search files share.
// ----------------------------------------------------------------------------
package npcs_pkg;

   localparam int COMP_W = 8;
   localparam int SQ_W   = 2 * COMP_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int OUT_W  = 8;
   localparam int CSR_W  = 9;

   localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(32000);
   localparam logic [CSR_W-1:0]  CSR_RESET  = CSR_W'(256);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } rgb_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage : npcs_pkg
`default_nettype wire

// ===== design/npcs_palette_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_palette_mem
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module npcs_palette_mem
   import npcs_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire rgb_type           wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output rgb_type                rd_data_ff
);

   rgb_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule : npcs_palette_mem
`default_nettype wire

// ===== design/npcs_dist_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_dist_unit
// Two-stage distance pipeline: squared channel differences, then sum and
// compare against the running best.
// ----------------------------------------------------------------------------
module npcs_dist_unit
   import npcs_pkg::*;
#(
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire rgb_type           query,
   input  wire logic              entry_vld,
   input  wire logic [ADDR_W-1:0] entry_idx,
   input  wire rgb_type           entry,
   output logic                   sq_vld_ff,
   output logic [ADDR_W-1:0]      best_idx_ff
);

   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SQ_W-1:0]   sq_r_in, sq_g_in, sq_b_in;
   logic [ADDR_W-1:0] idx_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic [DIST_W-1:0] distance;
   logic              better;

   function automatic logic [SQ_W-1:0] sq_diff(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   assign sq_r_in = sq_diff(entry.red, query.red);
   assign sq_g_in = sq_diff(entry.green, query.green);
   assign sq_b_in = sq_diff(entry.blue, query.blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= entry_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_vld) begin
         sq_r_ff <= sq_r_in;
         sq_g_ff <= sq_g_in;
         sq_b_ff <= sq_b_in;
         idx_ff  <= entry_idx;
      end
   end

   assign distance = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
   // strict compare keeps the lowest index on ties
   assign better   = sq_vld_ff && (distance < best_dist_ff);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         best_dist_ff <= DIST_LIMIT;
         best_idx_ff  <= '0;
      end else if (better) begin
         best_dist_ff <= distance;
         best_idx_ff  <= idx_ff;
      end
   end

endmodule : npcs_dist_unit
`default_nettype wire

// ===== design/nearest_palette_color_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette of RGB entries with a nearest-colour query by squared distance.
//
//   channel   ports                                  handshake
//   request   req_command/entry_index/red/green/blue start, busy
//   response  rsp_nearest_index                      rsp_strobe (one cycle)
//   config    csr_wr_data (entries in use)           csr_wr_en
//
// A palette write leaves busy low.
// A query of n entries holds busy while it runs: one
// palette read a cycle on the single read port, then the pipeline drains.
// The result strobe comes in the first cycle with busy low; a new transaction
// may be started in that same cycle.
// The palette is not cleared at reset; entries must be written before use.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module nearest_palette_color_search
   import npcs_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_command,
   input  wire logic [7:0]        req_entry_index,
   input  wire logic [COMP_W-1:0] req_red,
   input  wire logic [COMP_W-1:0] req_green,
   input  wire logic [COMP_W-1:0] req_blue,
   output logic                   rsp_strobe,
   output logic [OUT_W-1:0]       rsp_nearest_index,
   input  wire logic              csr_wr_en,
   input  wire logic [CSR_W-1:0]  csr_wr_data
);

   localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CNT_A  = $clog2(PALETTE_DEPTH + 1);
   localparam int CNT_W  = (CNT_A > CSR_W) ? CNT_A : CSR_W;
   localparam int IDX_W  = (ADDR_W > OUT_W) ? ADDR_W : OUT_W;
   localparam int WIDX_W = (CNT_W > 8) ? CNT_W : 8;

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  entries_in_use_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   rgb_type           query_ff, query_in;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_W-1:0]  rsp_index_ff;

   logic              accept, wr_en, wr_in_range, query_go, rd_en, clear;
   logic [WIDX_W-1:0] wr_idx_ext;
   logic [CNT_W-1:0]  cnt_cfg, cnt_sat;
   rgb_type           req_rgb, rd_data;
   logic              sq_vld;
   logic [ADDR_W-1:0] best_idx;
   logic [IDX_W-1:0]  best_ext;

   assign req_rgb     = '{red: req_red, green: req_green, blue: req_blue};
   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign wr_idx_ext  = WIDX_W'(req_entry_index);
   assign wr_in_range = (wr_idx_ext < WIDX_W'(PALETTE_DEPTH));
   assign wr_en       = accept && (req_command == CMD_WRITE) && wr_in_range;
   assign query_go    = accept && (req_command == CMD_QUERY);

   assign cnt_cfg = CNT_W'(entries_in_use_ff);
   assign cnt_sat = (cnt_cfg > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : cnt_cfg;

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      query_in      = query_ff;
      rd_en         = 1'b0;
      clear         = 1'b0;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               clear    = 1'b1;
               query_in = req_rgb;
               addr_in  = '0;
               last_in  = ADDR_W'(cnt_sat - CNT_W'(1));
               state_in = (cnt_sat == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // best is final once nothing is left in the distance pipeline
            if (!rd_vld_ff && !sq_vld) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         entries_in_use_ff <= CSR_RESET;
         rd_vld_ff         <= 1'b0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_en;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            entries_in_use_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      last_ff   <= last_in;
      query_ff  <= query_in;
      rd_idx_ff <= addr_ff;
      if (rsp_strobe_in) begin
         rsp_index_ff <= best_ext[OUT_W-1:0];
      end
   end

   assign best_ext = IDX_W'(best_idx);

   npcs_palette_mem #(
      .DEPTH  (PALETTE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (ADDR_W'(wr_idx_ext)),
      .wr_data    (req_rgb),
      .rd_en      (rd_en),
      .rd_addr    (addr_ff),
      .rd_data_ff (rd_data)
   );

   npcs_dist_unit #(
      .ADDR_W (ADDR_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .query       (query_ff),
      .entry_vld   (rd_vld_ff),
      .entry_idx   (rd_idx_ff),
      .entry       (rd_data),
      .sq_vld_ff   (sq_vld),
      .best_idx_ff (best_idx)
   );

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_nearest_index = rsp_index_ff;

   a_query_busy : assert property (@(posedge clock) disable iff (reset)
      query_go |=> busy)
      else $error("query transaction did not raise busy");

   a_strobe_after_drain : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DRAIN))
      else $error("response strobe without a finished scan");

   a_read_only_scanning : assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !wr_en)
      else $error("palette write during a scan");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

endmodule : nearest_palette_color_search
`default_nettype wire
